>>> hdl/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and register codes for the anti-windup PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pidaw_pkg;

    // Width of samples, gains, limits and drive values
    localparam int DataW  = 16;
    // Width of the integral accumulator and of the output sum
    localparam int AccW   = 32;
    // Configuration bus widths
    localparam int PAddrW = 5;
    localparam int PDataW = 32;

    typedef logic signed [DataW-1:0] sample_t;
    typedef logic [AccW-1:0]         acc_t;

    // Register codes, taken from the word address paddr[4:2]
    typedef enum logic [2:0] {
        REG_GAIN_PROP  = 3'd0,
        REG_GAIN_INTEG = 3'd1,
        REG_GAIN_DERIV = 3'd2,
        REG_OUT_MIN    = 3'd3,
        REG_OUT_MAX    = 3'd4
    } reg_idx_t;

    // Reset values of the output limits
    localparam sample_t OutMinReset = 16'sh8000;
    localparam sample_t OutMaxReset = 16'sh7FFF;

    // Gains and limits as seen by the datapath
    typedef struct packed {
        logic signed [DataW-1:0] gain_prop;
        logic signed [DataW-1:0] gain_integ;
        logic signed [DataW-1:0] gain_deriv;
        logic signed [DataW-1:0] out_min;
        logic signed [DataW-1:0] out_max;
    } pidaw_cfg_t;

    // Result of one controller step
    typedef struct packed {
        logic signed [DataW-1:0] drive_limited;
        logic signed [DataW-1:0] drive_raw;
    } pidaw_res_t;

endpackage

`default_nettype wire

>>> hdl/pidaw_step.sv
// ----------------------------------------------------------------------------
// pidaw_step
// One PID step: conditional integration, output sum and clamping, with the
// controller state registers that carry from one sample to the next.
// ----------------------------------------------------------------------------
`default_nettype none

module pidaw_step
    import pidaw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step_en,
    input  wire sample_t    err_in,
    input  wire pidaw_cfg_t cfg,
    output pidaw_res_t      res
);

    acc_t    integral_reg,    integral_next;
    sample_t prev_error_reg;
    sample_t last_limited_reg;
    sample_t last_raw_reg;

    logic                   hold_high;
    logic                   hold_low;
    logic signed [AccW-1:0] prod_integ;
    logic signed [AccW-1:0] prod_prop;
    logic signed [DataW:0]  err_diff;
    logic signed [AccW-1:0] prod_deriv;
    acc_t                   sum;
    sample_t                raw_hi;
    sample_t                lim_hi;

    // Skip integration while the last output sat on a limit and this error
    // would push further into it
    always_comb
    begin
        hold_high = (last_limited_reg < last_raw_reg) && !err_in[DataW-1];
        hold_low  = (last_raw_reg < last_limited_reg) && err_in[DataW-1];
    end

    // Products of the three terms, wrapped to the accumulator width
    always_comb
    begin
        prod_integ = AccW'(cfg.gain_integ) * AccW'(err_in);
        prod_prop  = AccW'(cfg.gain_prop) * AccW'(err_in);
        err_diff   = {err_in[DataW-1], err_in} - {prev_error_reg[DataW-1], prev_error_reg};
        prod_deriv = AccW'(cfg.gain_deriv) * AccW'(err_diff);
    end

    // Accumulate, sum with wraparound and clamp the high half when the limits are ordered
    always_comb
    begin
        if (hold_high || hold_low)
        begin
            integral_next = integral_reg;
        end
        else
        begin
            integral_next = integral_reg + acc_t'(prod_integ);
        end
        sum    = acc_t'(prod_prop) + integral_next + acc_t'(prod_deriv);
        raw_hi = sample_t'(sum[AccW-1:AccW-DataW]);
        lim_hi = raw_hi;
        if (cfg.out_min < cfg.out_max)
        begin
            priority if (raw_hi > cfg.out_max)
            begin
                lim_hi = cfg.out_max;
            end
            else if (raw_hi < cfg.out_min)
            begin
                lim_hi = cfg.out_min;
            end
        end
        res.drive_limited = lim_hi;
        res.drive_raw     = raw_hi;
    end

    // Advance controller state once per accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg     <= '0;
            prev_error_reg   <= '0;
            last_limited_reg <= '0;
            last_raw_reg     <= '0;
        end
        else if (step_en)
        begin
            integral_reg     <= integral_next;
            prev_error_reg   <= err_in;
            last_limited_reg <= lim_hi;
            last_raw_reg     <= raw_hi;
        end
    end

`ifndef SYNTHESIS
    // Integral must not move while the output is wound up against a limit
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (hold_high || hold_low) |=> $stable(integral_reg))
        else $error("pidaw_step: integral changed during windup hold");

    // Saved limited output stays within the limits whenever they are ordered
    assert property (@(posedge clk) disable iff (!rst_n)
        step_en && (cfg.out_min < cfg.out_max) |=>
            (last_limited_reg <= $past(cfg.out_max))
            && (last_limited_reg >= $past(cfg.out_min)))
        else $error("pidaw_step: stored limited output outside limits");
`endif

endmodule

`default_nettype wire

>>> hdl/pid_controller_anti_windup_core.sv
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_core
// PID controller with conditional-integration anti-windup and output limits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, error_sample) carries one signed error
//   sample per request. Output channel (out_valid/out_ready, drive_limited,
//   drive_raw) returns one result per sample, in order.
//   Gains and limits are written over the APB port at byte addresses 0x00
//   (gain_prop), 0x04 (gain_integ), 0x08 (gain_deriv), 0x0C (out_min) and
//   0x10 (out_max); write them only while no sample is in flight.
// Timing:
//   An accepted sample waits in the input register until the result slot is
//   free; then its result is loaded into the output register and out_valid rises.
//   Throughput is one sample per cycle while out_ready stays high; the bound is
//   the integral feedback loop, which closes combinationally through the
//   multiply-add and clamp.
// Reset:
//   Integral, previous error and saved outputs clear to zero, gains to zero,
//   limits to the full 16-bit range. Both channels come up empty.
// Stalls:
//   With out_ready low the result holds; one more sample can be taken into
//   the input register, after which in_ready drops until the result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_controller_anti_windup_core
    import pidaw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [PAddrW-1:0] paddr,
    input  wire logic [PDataW-1:0] pwdata,
    output logic      [PDataW-1:0] prdata,
    output logic                   pready,
    // sample input
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire sample_t           error_sample,
    // drive output
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sample_t                drive_limited,
    output sample_t                drive_raw
);

    pidaw_cfg_t cfg_reg;
    reg_idx_t   reg_idx;
    logic       cfg_wr;
    sample_t    rd_val;

    logic       stage_valid_reg;
    sample_t    stage_err_reg;
    logic       out_valid_reg;
    pidaw_res_t res_reg;
    pidaw_res_t step_res;
    logic       advance;
    logic       in_take;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PAddrW-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_prop  <= '0;
            cfg_reg.gain_integ <= '0;
            cfg_reg.gain_deriv <= '0;
            cfg_reg.out_min    <= OutMinReset;
            cfg_reg.out_max    <= OutMaxReset;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_GAIN_PROP:  cfg_reg.gain_prop  <= sample_t'(pwdata[DataW-1:0]);
                REG_GAIN_INTEG: cfg_reg.gain_integ <= sample_t'(pwdata[DataW-1:0]);
                REG_GAIN_DERIV: cfg_reg.gain_deriv <= sample_t'(pwdata[DataW-1:0]);
                REG_OUT_MIN:    cfg_reg.out_min    <= sample_t'(pwdata[DataW-1:0]);
                REG_OUT_MAX:    cfg_reg.out_max    <= sample_t'(pwdata[DataW-1:0]);
                default:        ;
            endcase
        end
    end

    // Read back, sign-extended to the bus width
    always_comb
    begin
        unique case (reg_idx)
            REG_GAIN_PROP:  rd_val = cfg_reg.gain_prop;
            REG_GAIN_INTEG: rd_val = cfg_reg.gain_integ;
            REG_GAIN_DERIV: rd_val = cfg_reg.gain_deriv;
            REG_OUT_MIN:    rd_val = cfg_reg.out_min;
            REG_OUT_MAX:    rd_val = cfg_reg.out_max;
            default:        rd_val = '0;
        endcase
        prdata = {{(PDataW-DataW){rd_val[DataW-1]}}, rd_val};
    end

    // Flow control: the input stage advances whenever the result slot frees
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || !out_valid_reg || out_ready;
    assign in_take  = in_valid && in_ready;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_err_reg <= error_sample;
        end
    end

    // Controller step
    pidaw_step u_step (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .err_in  (stage_err_reg),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    // Result register: load on advance, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign drive_limited = res_reg.drive_limited;
    assign drive_raw     = res_reg.drive_raw;

`ifndef SYNTHESIS
    // An accepted request always lands in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> stage_valid_reg)
        else $error("core: accepted request lost");

    // A step always produces a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("core: step result not registered");

    // Ordered limits bound the limited drive
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && (cfg_reg.out_min < cfg_reg.out_max) |->
            (drive_limited <= cfg_reg.out_max) && (drive_limited >= cfg_reg.out_min))
        else $error("core: limited drive outside limits");

    // Unordered limits pass the raw drive through
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && !(cfg_reg.out_min < cfg_reg.out_max) |->
            (drive_limited == drive_raw))
        else $error("core: clamp applied with unordered limits");
`endif

endmodule

`default_nettype wire

>>> tb/pid_controller_anti_windup_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_anti_windup_core_tb
// Self-checking bench for the anti-windup PID core. Gains and limits go in
// over the APB port while the core is idle. Error samples stream through the
// valid/ready channels, with random gaps on both sides. An in-bench model of
// the integral, the clamp and the windup hold predicts each drive result, and
// the bench compares it with what the core returns, in order.
// ----------------------------------------------------------------------------

module pid_controller_anti_windup_core_tb;
    import pidaw_pkg::*;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [PAddrW-1:0] paddr = '0;
    logic [PDataW-1:0] pwdata = '0;
    logic [PDataW-1:0] prdata;
    logic              pready;
    logic              in_valid = 1'b0;
    logic              in_ready;
    sample_t           error_sample = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    sample_t           drive_limited;
    sample_t           drive_raw;

    // Samples waiting to be sent and drive results still owed by the core
    sample_t    err_pending[$];
    pidaw_res_t drive_expect_q[$];

    int send_gap_pct = 9;
    int recv_stall_pct = 46;
    int mismatch_cnt = 0;

    // Shadow copy of the gain and limit registers
    sample_t cfg_kp  = '0;
    sample_t cfg_ki  = '0;
    sample_t cfg_kd  = '0;
    sample_t cfg_min = OutMinReset;
    sample_t cfg_max = OutMaxReset;

    // Controller state as the core should hold it
    logic signed [AccW-1:0] integ_acc = '0;
    sample_t                prev_err = '0;
    sample_t                last_lim = '0;
    sample_t                last_raw = '0;

    pid_controller_anti_windup_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .error_sample  (error_sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive_limited (drive_limited),
        .drive_raw     (drive_raw)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("pid_controller_anti_windup_core_tb NOT OK");
        $finish;
    end

    // Advance the model by one sample and return the drive it should produce
    function automatic pidaw_res_t pid_step(sample_t err);
        logic                   hold_hi;
        logic                   hold_lo;
        logic signed [16:0]     diff;
        logic signed [AccW-1:0] p_term;
        logic signed [AccW-1:0] i_step;
        logic signed [AccW-1:0] d_term;
        logic signed [AccW-1:0] sum;
        sample_t                raw;
        sample_t                lim;
        pidaw_res_t             res;
        hold_hi = (last_lim < last_raw) && (err >= 0);
        hold_lo = (last_raw < last_lim) && (err < 0);
        i_step = cfg_ki * err;
        if (!hold_hi && !hold_lo)
            integ_acc = integ_acc + i_step;
        diff = err - prev_err;
        p_term = cfg_kp * err;
        d_term = cfg_kd * diff;
        sum = p_term + integ_acc + d_term;
        raw = sum[31:16];
        lim = raw;
        if (cfg_min < cfg_max)
        begin
            if (raw > cfg_max)
                lim = cfg_max;
            else if (raw < cfg_min)
                lim = cfg_min;
        end
        prev_err = err;
        last_raw = raw;
        last_lim = lim;
        res.drive_limited = lim;
        res.drive_raw = raw;
        return res;
    endfunction

    function automatic sample_t rand_err();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return sample_t'($urandom_range(0, 64)) - 16'sd32;
            default: return sample_t'($urandom);
        endcase
    endfunction

    // Driver: predict on each accepted request, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            error_sample <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                drive_expect_q.push_back(pid_step(error_sample));
            if (!in_valid || in_ready)
            begin
                if (err_pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    in_valid     <= 1'b1;
                    error_sample <= err_pending.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each returned drive against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (drive_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected drive result limited %0d raw %0d",
                             $time, drive_limited, drive_raw);
                    mismatch_cnt++;
                end
                else
                begin
                    if (drive_expect_q[0].drive_limited !== drive_limited)
                    begin
                        $display("%0t: drive_limited expected %0d got %0d", $time,
                                 drive_expect_q[0].drive_limited, drive_limited);
                        mismatch_cnt++;
                    end
                    if (drive_expect_q[0].drive_raw !== drive_raw)
                    begin
                        $display("%0t: drive_raw expected %0d got %0d", $time,
                                 drive_expect_q[0].drive_raw, drive_raw);
                        mismatch_cnt++;
                    end
                    void'(drive_expect_q.pop_front());
                end
            end
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Hold until every sample is sent and every result is back
    task automatic wait_drain();
        do
            @(negedge clk);
        while (err_pending.size() != 0 || in_valid || drive_expect_q.size() != 0);
        repeat (3) @(negedge clk);
    endtask

    // Two-phase APB write; the register takes the data on the access edge
    task automatic apb_write(input logic [PAddrW-1:0] addr, input logic [PDataW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg(input reg_idx_t idx, input sample_t val);
        logic [15:0] junk;
        junk = 16'($urandom);
        apb_write({idx, 2'b00}, {junk, val});
        case (idx)
            REG_GAIN_PROP:  cfg_kp  = val;
            REG_GAIN_INTEG: cfg_ki  = val;
            REG_GAIN_DERIV: cfg_kd  = val;
            REG_OUT_MIN:    cfg_min = val;
            REG_OUT_MAX:    cfg_max = val;
            default:        ;
        endcase
    endtask

    task automatic set_gains(input sample_t kp, input sample_t ki, input sample_t kd,
                             input sample_t mn, input sample_t mx);
        write_reg(REG_GAIN_PROP, kp);
        write_reg(REG_GAIN_INTEG, ki);
        write_reg(REG_GAIN_DERIV, kd);
        write_reg(REG_OUT_MIN, mn);
        write_reg(REG_OUT_MAX, mx);
    endtask

    // Pick one gain and limit setting for a random phase
    task automatic pick_settings(input int profile);
        sample_t a;
        sample_t b;
        case (profile)
            0:
            begin
                set_gains(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          sample_t'($urandom), sample_t'($urandom));
            end
            1:
            begin
                set_gains(sample_t'($urandom_range(0, 511)) - 16'sd256,
                          sample_t'($urandom_range(0, 8191)) - 16'sd4096,
                          sample_t'($urandom_range(0, 511)) - 16'sd256,
                          -sample_t'($urandom_range(1, 2000)),
                          sample_t'($urandom_range(1, 2000)));
            end
            2:
            begin
                set_gains($urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                          $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                          $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000,
                          16'sh8000, 16'sh7FFF);
            end
            default:
            begin
                // Limits out of order or equal: clamp must stay off
                a = sample_t'($urandom);
                b = $urandom_range(0, 3) == 0 ? a : sample_t'($urandom);
                set_gains(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom),
                          (a > b) ? a : b, (a > b) ? b : a);
            end
        endcase
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset gains: everything must come back as zero
        err_pending.push_back(16'sh7FFF);
        err_pending.push_back(16'sh8000);
        wait_drain();

        // Narrow limits: drive into the high clamp, then the low one
        set_gains(16'sd256, 16'sd4096, -16'sd512, -16'sd100, 16'sd100);
        @(negedge clk);
        repeat (3) err_pending.push_back(16'sh7FFF);
        repeat (4) err_pending.push_back(16'sh8000);
        err_pending.push_back(16'sd0);
        err_pending.push_back(16'sd1);
        err_pending.push_back(-16'sd1);
        err_pending.push_back(16'sh5555);
        err_pending.push_back(16'shAAAA);
        wait_drain();

        // Extreme gains, equal limits, full-swing derivative step
        set_gains(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sd5, 16'sd5);
        @(negedge clk);
        err_pending.push_back(16'sh7FFF);
        err_pending.push_back(16'sh8000);
        err_pending.push_back(16'sh7FFF);
        err_pending.push_back(16'sh8000);
        wait_drain();

        // Inverted limits, then writes past the last register
        write_reg(REG_OUT_MIN, 16'sd100);
        write_reg(REG_OUT_MAX, -16'sd100);
        @(negedge clk);
        err_pending.push_back(16'sh1234);
        err_pending.push_back(-16'sd1);
        wait_drain();
        for (k = REG_OUT_MAX + 1; k < 8; k++)
            apb_write(PAddrW'(k * 4), $urandom);
        @(negedge clk);
        err_pending.push_back(16'sh7FFF);
        err_pending.push_back(16'sh8000);
        wait_drain();

        // Random phases; sender pauses mid-phase until the core drains
        for (int phase = 0; phase < 6; phase++)
        begin
            pick_settings(phase % 4);
            @(negedge clk);
            case (phase / 2)
                0:
                begin
                    send_gap_pct   = 9;
                    recv_stall_pct = 46;
                end
                1:
                begin
                    send_gap_pct   = 46;
                    recv_stall_pct = 9;
                end
                default:
                begin
                    send_gap_pct   = 0;
                    recv_stall_pct = 0;
                end
            endcase
            repeat (40) err_pending.push_back(rand_err());
            wait_drain();
            repeat (40) err_pending.push_back(rand_err());
            wait_drain();
        end

        repeat (5) @(negedge clk);
        if (drive_expect_q.size() != 0)
            mismatch_cnt++;
        if (mismatch_cnt == 0)
            $display("pid_controller_anti_windup_core_tb OK");
        else
            $display("pid_controller_anti_windup_core_tb NOT OK");
        $finish;
    end

endmodule

>>> sim.f
hdl/pidaw_pkg.sv
hdl/pidaw_step.sv
hdl/pid_controller_anti_windup_core.sv
tb/pid_controller_anti_windup_core_tb.sv
